>>> rtl/core/ddopt_pkg.sv
`default_nettype none
package ddopt_pkg;

	localparam int MD_A_W        = 64;
	localparam int MD_B_W        = 34;
	localparam int MD_REM_W      = 33;
	localparam int MD_CNT_W      = 7;
	localparam int MD_MUL_STEPS  = 34;
	localparam int MD_DIV_STEPS  = 64;
	localparam int TRIG_W        = 34;
	localparam int TRIG_CNT_W    = 6;

	localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic [MD_B_W-1:0] PI180_Q32 = 34'd74961321;
	localparam logic [MD_B_W-1:0] RAD2BA    = 34'd683565276;

	typedef enum logic {
		MD_MUL = 1'b0,
		MD_DIV = 1'b1
	} md_op_t;

	typedef struct packed {
		logic              start;
		md_op_t            op;
		logic [MD_A_W-1:0] a;
		logic [MD_B_W-1:0] b;
	} md_req_t;

	typedef struct packed {
		logic              done;
		logic [MD_A_W-1:0] result;
	} md_rsp_t;

	typedef struct packed {
		logic              done;
		logic [TRIG_W-1:0] cos;
		logic [TRIG_W-1:0] sin;
	} trig_rsp_t;

	// arctangent of 2^-i as a 32-bit binary angle
	function automatic logic [31:0] atan_ba(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/ddopt_md.sv
`default_nettype none
module ddopt_md
	import ddopt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  md_req_t   req,
	output md_rsp_t   rsp
);

	logic                       busy_q;
	logic                       done_q;
	logic                       neg_q;
	md_op_t                     op_q;
	logic [MD_CNT_W-1:0]        cnt_q;
	logic [MD_A_W-1:0]          a_q;
	logic [MD_A_W-1:0]          acc_q;
	logic signed [MD_B_W-1:0]   b_q;
	logic                       last;
	logic [MD_A_W-1:0]          addend;
	logic [MD_REM_W-1:0]        rem_sh;
	logic [MD_REM_W-1:0]        divisor;
	logic [MD_REM_W-1:0]        rem_nxt;
	logic                       ge;

	assign last = (op_q == MD_MUL) ? (cnt_q == MD_CNT_W'(MD_MUL_STEPS - 1))
		: (cnt_q == MD_CNT_W'(MD_DIV_STEPS - 1));
	assign addend  = b_q[0] ? a_q : '0;
	assign rem_sh  = {acc_q[MD_REM_W-2:0], a_q[MD_A_W-1]};
	assign divisor = {1'b0, b_q[MD_REM_W-2:0]};
	assign ge      = (rem_sh >= divisor);
	assign rem_nxt = ge ? (rem_sh - divisor) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && last) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// shift-add multiply (multiplier sign bit weighs negative), restoring divide on magnitudes
	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			cnt_q <= '0;
			acc_q <= '0;
			b_q   <= req.b;
			neg_q <= req.a[MD_A_W-1];
			if (req.op == MD_DIV && req.a[MD_A_W-1]) begin
				a_q <= -req.a;
			end else begin
				a_q <= req.a;
			end
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			case (op_q)
				MD_MUL: begin
					acc_q <= last ? (acc_q - addend) : (acc_q + addend);
					a_q   <= {a_q[MD_A_W-2:0], 1'b0};
					b_q   <= b_q >>> 1;
				end
				MD_DIV: begin
					acc_q <= MD_A_W'(rem_nxt);
					a_q   <= {a_q[MD_A_W-2:0], ge};
				end
				default: acc_q <= acc_q;
			endcase
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = (op_q == MD_MUL) ? acc_q : (neg_q ? -a_q : a_q);

endmodule
`default_nettype wire

>>> rtl/core/ddopt_cordic.sv
`default_nettype none
module ddopt_cordic
	import ddopt_pkg::*;
#(
	parameter int TRIG_ITERATIONS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] angle,
	output trig_rsp_t        rsp
);

	logic                      busy_q;
	logic                      done_q;
	logic                      flip_q;
	logic [TRIG_CNT_W-1:0]     it_q;
	logic signed [TRIG_W-1:0]  x_q;
	logic signed [TRIG_W-1:0]  y_q;
	logic signed [TRIG_W-1:0]  z_q;
	logic signed [TRIG_W-1:0]  xs;
	logic signed [TRIG_W-1:0]  ys;
	logic signed [TRIG_W-1:0]  step_ang;
	logic [31:0]               quarter;
	logic [31:0]               folded;
	logic                      flip;
	logic                      last;

	// fold the angle into the right half plane, negate the result afterwards
	assign quarter  = angle + 32'h40000000;
	assign flip     = quarter[31];
	assign folded   = flip ? (angle + 32'h80000000) : angle;
	assign xs       = x_q >>> it_q;
	assign ys       = y_q >>> it_q;
	assign step_ang = signed'(TRIG_W'(atan_ba(it_q[4:0])));
	assign last     = (it_q == TRIG_CNT_W'(TRIG_ITERATIONS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && last) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			flip_q <= flip;
			it_q   <= '0;
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= signed'({{(TRIG_W-32){folded[31]}}, folded});
		end else if (busy_q) begin
			it_q <= it_q + 1'b1;
			if (!z_q[TRIG_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - step_ang;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + step_ang;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.cos  = flip_q ? -x_q : x_q;
	assign rsp.sin  = flip_q ? -y_q : y_q;

endmodule
`default_nettype wire

>>> rtl/core/diff_drive_odometry_pd_tracker_unit.sv
// one word in flight: in_stall is high from accept until the result is queued, and a new
//   word is accepted only once the finished word has moved to the result register
// each step is issued to the bit-serial multiply/divide unit, or to the CORDIC unit for the
//   two trig steps, and waits for its done; the result register lets the next word in
//   while the last result waits to be taken
// reset: pose, heading, encoder and error history cleared; gains and geometry to defaults
`default_nettype none
module diff_drive_odometry_pd_tracker_unit
	import ddopt_pkg::*;
#(
	parameter int TRIG_ITERATIONS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] encoder_a,
	input  wire logic signed [31:0] encoder_b,
	input  wire logic signed [31:0] target_x,
	input  wire logic signed [31:0] target_y,
	input  wire logic [15:0]        elapsed_ticks,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [7:0]       power_a,
	output logic signed [7:0]       power_b,
	output logic signed [31:0]      est_x,
	output logic signed [31:0]      est_y,
	output logic [15:0]             est_heading
);

	localparam logic [2:0] CFG_PROP_GAIN    = 3'd0;
	localparam logic [2:0] CFG_DERIV_GAIN   = 3'd1;
	localparam logic [2:0] CFG_WHEEL_RADIUS = 3'd2;
	localparam logic [2:0] CFG_WHEEL_BASE   = 3'd3;
	localparam logic [2:0] CFG_POWER_SCALE  = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ISSUE = 4'b0010,
		ST_WAIT  = 4'b0100,
		ST_HOLD  = 4'b1000
	} state_t;

	typedef enum logic [4:0] {
		STP_TRA0, STP_TRA1, STP_TRB0, STP_TRB1, STP_TURN, STP_ANG, STP_TRIG_MID,
		STP_PX, STP_PY, STP_EX, STP_EY, STP_DX, STP_UX, STP_DY, STP_UY,
		STP_TRIG_HEAD, STP_F0, STP_F1, STP_R0, STP_R1, STP_HR, STP_PA, STP_PB
	} step_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648) return 32'sh80000000;
		else return v[31:0];
	endfunction

	function automatic logic signed [20:0] clamp_delta(input logic signed [31:0] d);
		if (d > 32'sd1048575) return 21'sd1048575;
		else if (d < -32'sd1048575) return -21'sd1048575;
		else return d[20:0];
	endfunction

	function automatic logic signed [41:0] clamp_cmd(input logic signed [43:0] v);
		if (v > 44'sd1099511627776) return 42'sd1099511627776;
		else if (v < -44'sd1099511627776) return -42'sd1099511627776;
		else return v[41:0];
	endfunction

	// divide by 2^24 rounding toward zero, then saturate to the motor range
	function automatic logic signed [7:0] to_power(input logic signed [63:0] p);
		logic signed [63:0] q;
		q = p[63] ? ((p + 64'sd16777215) >>> 24) : (p >>> 24);
		if (q > 64'sd100) return 8'sd100;
		else if (q < -64'sd100) return -8'sd100;
		else return q[7:0];
	endfunction

	state_t state_q;
	step_t  step_q;

	logic signed [15:0] prop_gain_q;
	logic signed [15:0] deriv_gain_q;
	logic [15:0]        wheel_radius_q;
	logic [15:0]        wheel_base_q;
	logic [15:0]        power_scale_q;

	logic [31:0]        prev_a_q;
	logic [31:0]        prev_b_q;
	logic signed [31:0] pos_x_q;
	logic signed [31:0] pos_y_q;
	logic [31:0]        heading_q;
	logic signed [31:0] perr_x_q;
	logic signed [31:0] perr_y_q;

	logic [31:0]        enc_a_q;
	logic [31:0]        enc_b_q;
	logic signed [31:0] tgt_x_q;
	logic signed [31:0] tgt_y_q;
	logic [15:0]        ticks_q;

	logic signed [63:0] prod_q;
	logic signed [31:0] ta_q;
	logic signed [31:0] tb_q;
	logic signed [40:0] turn_q;
	logic [31:0]        half_q;
	logic [31:0]        dhead_q;
	logic signed [31:0] dx_q;
	logic signed [31:0] dy_q;
	logic signed [31:0] ux_q;
	logic signed [31:0] uy_q;
	logic signed [34:0] fwd_q;
	logic signed [34:0] rot_q;
	logic signed [42:0] hr_q;
	logic signed [7:0]  pwr_a_q;
	logic signed [7:0]  pwr_b_q;

	logic               out_valid_q;
	logic signed [7:0]  out_pa_q;
	logic signed [7:0]  out_pb_q;
	logic signed [31:0] out_x_q;
	logic signed [31:0] out_y_q;
	logic [15:0]        out_h_q;

	md_req_t            md_req;
	md_rsp_t            md_rsp;
	trig_rsp_t          trig_rsp;
	logic               trig_start;
	logic [31:0]        trig_angle;

	logic               accept;
	logic               trig_step;
	logic               unit_done;
	logic               out_free;
	logic signed [63:0] p;
	logic signed [20:0] del_a;
	logic signed [20:0] del_b;
	logic signed [32:0] tsum;
	logic signed [31:0] v;
	logic signed [32:0] tdiff;
	logic signed [40:0] turn_num;
	logic [15:0]        base_eff;
	logic signed [32:0] ex;
	logic signed [32:0] ey;
	logic signed [32:0] ddx;
	logic signed [32:0] ddy;
	logic signed [23:0] kd_w;
	logic signed [23:0] kd100;
	logic signed [43:0] cmd_a;
	logic signed [43:0] cmd_b;
	logic signed [63:0] f_sum;
	logic signed [63:0] r_diff;
	logic signed [63:0] f_sh;
	logic signed [63:0] r_sh;
	logic signed [63:0] hr_sh;
	logic signed [63:0] ux_sum;
	logic signed [63:0] uy_sum;
	logic signed [63:0] px_sum;
	logic signed [63:0] py_sum;
	logic signed [63:0] ta_sh;
	logic signed [63:0] tb_sh;
	logic signed [63:0] e_sh;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign trig_step = (step_q == STP_TRIG_MID) || (step_q == STP_TRIG_HEAD);
	assign unit_done = trig_step ? trig_rsp.done : md_rsp.done;
	assign out_free  = !out_valid_q || !out_stall;
	assign p         = signed'(md_rsp.result);

	assign del_a    = clamp_delta(signed'(enc_a_q - prev_a_q));
	assign del_b    = clamp_delta(signed'(enc_b_q - prev_b_q));
	assign tsum     = {ta_q[31], ta_q} + {tb_q[31], tb_q};
	assign v        = tsum[32:1];
	assign tdiff    = {tb_q[31], tb_q} - {ta_q[31], ta_q};
	assign turn_num = {tdiff, 8'h00};
	assign base_eff = (wheel_base_q == 16'd0) ? 16'd1 : wheel_base_q;
	assign ex       = {tgt_x_q[31], tgt_x_q} - {pos_x_q[31], pos_x_q};
	assign ey       = {tgt_y_q[31], tgt_y_q} - {pos_y_q[31], pos_y_q};
	assign ddx      = {dx_q[31], dx_q} - {perr_x_q[31], perr_x_q};
	assign ddy      = {dy_q[31], dy_q} - {perr_y_q[31], perr_y_q};
	assign kd_w     = {{8{deriv_gain_q[15]}}, deriv_gain_q};
	// times 100 as 64 + 32 + 4
	assign kd100    = (kd_w <<< 6) + (kd_w <<< 5) + (kd_w <<< 2);
	assign cmd_a    = {{9{fwd_q[34]}}, fwd_q} - {hr_q[42], hr_q};
	assign cmd_b    = {{9{fwd_q[34]}}, fwd_q} + {hr_q[42], hr_q};
	assign f_sum    = prod_q + p;
	assign r_diff   = prod_q - p;
	assign f_sh     = f_sum >>> 30;
	assign r_sh     = r_diff >>> 30;
	assign hr_sh    = p >>> 9;
	assign ux_sum   = 64'(dx_q) + p;
	assign uy_sum   = 64'(dy_q) + p;
	assign px_sum   = 64'(pos_x_q) + (p >>> 30);
	assign py_sum   = 64'(pos_y_q) + (p >>> 30);
	assign ta_sh    = p >>> 24;
	assign tb_sh    = ta_sh;
	assign e_sh     = p >>> 8;

	always_comb begin
		md_req.start = 1'b0;
		md_req.op    = MD_MUL;
		md_req.a     = '0;
		md_req.b     = '0;
		trig_start   = 1'b0;
		trig_angle   = heading_q;
		if (state_q == ST_ISSUE) begin
			md_req.start = !trig_step;
			case (step_q)
				STP_TRA0: begin
					md_req.a = 64'(del_a);
					md_req.b = MD_B_W'(wheel_radius_q);
				end
				STP_TRA1, STP_TRB1: begin
					md_req.a = prod_q;
					md_req.b = PI180_Q32;
				end
				STP_TRB0: begin
					md_req.a = 64'(del_b);
					md_req.b = MD_B_W'(wheel_radius_q);
				end
				STP_TURN: begin
					md_req.op = MD_DIV;
					md_req.a  = 64'(turn_num);
					md_req.b  = MD_B_W'(base_eff);
				end
				STP_ANG: begin
					md_req.a = 64'(turn_q);
					md_req.b = RAD2BA;
				end
				STP_TRIG_MID: begin
					trig_start = 1'b1;
					trig_angle = heading_q + half_q;
				end
				STP_PX: begin
					md_req.a = 64'(v);
					md_req.b = trig_rsp.cos;
				end
				STP_PY: begin
					md_req.a = 64'(v);
					md_req.b = trig_rsp.sin;
				end
				STP_EX: begin
					md_req.a = 64'(ex);
					md_req.b = MD_B_W'(prop_gain_q);
				end
				STP_EY: begin
					md_req.a = 64'(ey);
					md_req.b = MD_B_W'(prop_gain_q);
				end
				STP_DX: begin
					md_req.a = 64'(ddx);
					md_req.b = MD_B_W'(kd100);
				end
				STP_DY: begin
					md_req.a = 64'(ddy);
					md_req.b = MD_B_W'(kd100);
				end
				STP_UX, STP_UY: begin
					md_req.op = MD_DIV;
					md_req.a  = prod_q;
					md_req.b  = MD_B_W'({ticks_q, 8'h00});
				end
				STP_TRIG_HEAD: begin
					trig_start = 1'b1;
				end
				STP_F0: begin
					md_req.a = 64'(ux_q);
					md_req.b = trig_rsp.cos;
				end
				STP_F1: begin
					md_req.a = 64'(uy_q);
					md_req.b = trig_rsp.sin;
				end
				STP_R0: begin
					md_req.a = 64'(uy_q);
					md_req.b = trig_rsp.cos;
				end
				STP_R1: begin
					md_req.a = 64'(ux_q);
					md_req.b = trig_rsp.sin;
				end
				STP_HR: begin
					md_req.a = 64'(rot_q);
					md_req.b = MD_B_W'(wheel_base_q);
				end
				STP_PA: begin
					md_req.a = 64'(clamp_cmd(cmd_a));
					md_req.b = MD_B_W'(power_scale_q);
				end
				STP_PB: begin
					md_req.a = 64'(clamp_cmd(cmd_b));
					md_req.b = MD_B_W'(power_scale_q);
				end
				default: md_req.start = 1'b0;
			endcase
		end
	end

	ddopt_md u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	ddopt_cordic #(
		.TRIG_ITERATIONS (TRIG_ITERATIONS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (trig_start),
		.angle  (trig_angle),
		.rsp    (trig_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			step_q         <= STP_TRA0;
			out_valid_q    <= 1'b0;
			prop_gain_q    <= 16'sd26;
			deriv_gain_q   <= -16'sd1280;
			wheel_radius_q <= 16'd717;
			wheel_base_q   <= 16'd2885;
			power_scale_q  <= 16'd26192;
			prev_a_q       <= '0;
			prev_b_q       <= '0;
			pos_x_q        <= '0;
			pos_y_q        <= '0;
			heading_q      <= '0;
			perr_x_q       <= '0;
			perr_y_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PROP_GAIN:    prop_gain_q    <= cfg_data;
					CFG_DERIV_GAIN:   deriv_gain_q   <= cfg_data;
					CFG_WHEEL_RADIUS: wheel_radius_q <= cfg_data;
					CFG_WHEEL_BASE:   wheel_base_q   <= cfg_data;
					CFG_POWER_SCALE:  power_scale_q  <= cfg_data;
					default:          prop_gain_q    <= prop_gain_q;
				endcase
			end

			// a finished word refills the result register in the cycle the old one leaves
			if (state_q == ST_HOLD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_ISSUE;
						step_q  <= STP_TRA0;
					end
				end
				ST_ISSUE: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (unit_done) begin
						case (step_q)
							STP_TRA1: prev_a_q <= enc_a_q;
							STP_TRB1: prev_b_q <= enc_b_q;
							STP_PX:   pos_x_q  <= sat32(px_sum);
							STP_PY: begin
								pos_y_q   <= sat32(py_sum);
								heading_q <= heading_q + dhead_q;
							end
							STP_UX:   perr_x_q <= dx_q;
							STP_UY:   perr_y_q <= dy_q;
							default:  heading_q <= heading_q;
						endcase
						if (step_q == STP_PB) begin
							state_q <= ST_HOLD;
						end else begin
							state_q <= ST_ISSUE;
							step_q  <= step_t'(step_q + 1'b1);
						end
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			enc_a_q <= encoder_a;
			enc_b_q <= encoder_b;
			tgt_x_q <= target_x;
			tgt_y_q <= target_y;
			ticks_q <= (elapsed_ticks == 16'd0) ? 16'd1 : elapsed_ticks;
		end
		if (state_q == ST_WAIT && unit_done) begin
			case (step_q)
				STP_TRA0, STP_TRB0, STP_DX, STP_DY, STP_F0, STP_R0: prod_q <= p;
				STP_TRA1: ta_q    <= sat32(ta_sh);
				STP_TRB1: tb_q    <= sat32(tb_sh);
				STP_TURN: turn_q  <= p[40:0];
				STP_ANG: begin
					half_q  <= p[48:17];
					dhead_q <= p[47:16];
				end
				STP_EX:   dx_q    <= sat32(e_sh);
				STP_EY:   dy_q    <= sat32(e_sh);
				STP_UX:   ux_q    <= sat32(ux_sum);
				STP_UY:   uy_q    <= sat32(uy_sum);
				STP_F1:   fwd_q   <= f_sh[34:0];
				STP_R1:   rot_q   <= r_sh[34:0];
				STP_HR:   hr_q    <= hr_sh[42:0];
				STP_PA:   pwr_a_q <= to_power(p);
				STP_PB:   pwr_b_q <= to_power(p);
				default:  prod_q  <= prod_q;
			endcase
		end
		if (state_q == ST_HOLD && out_free) begin
			out_pa_q <= pwr_a_q;
			out_pb_q <= pwr_b_q;
			out_x_q  <= pos_x_q;
			out_y_q  <= pos_y_q;
			out_h_q  <= heading_q[31:16];
		end
	end

	assign out_valid   = out_valid_q;
	assign power_a     = out_pa_q;
	assign power_b     = out_pb_q;
	assign est_x       = out_x_q;
	assign est_y       = out_y_q;
	assign est_heading = out_h_q;

	a_md_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		md_rsp.done |-> (state_q == ST_WAIT && !trig_step))
		else $error("multiply/divide result arrived outside a wait step");

	a_trig_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		trig_rsp.done |-> (state_q == ST_WAIT && trig_step))
		else $error("cordic result arrived outside a trig step");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_ISSUE && step_q == STP_TRA0))
		else $error("accepted word did not start the sequence");

	a_hold_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HOLD && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished word not moved to the result register");

endmodule
`default_nettype wire
